// ===== hw/rtl/cabc_pkg.sv =====
// Package for the clipped alpha-blend compositor.
// Holds register indexes, field widths and size limits; no dependencies.
`default_nettype none

package cabc_pkg;

    localparam int MAX_SIDE     = 4096;
    localparam int CHAN_W       = 8;
    localparam int WEIGHT_W     = 9;
    localparam int PLACE_W      = 12;
    localparam int SIZE_W       = 13;
    localparam int COUNT_W      = 12;
    localparam int ADDR_W       = 24;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 48;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(256);
    localparam logic [SIZE_W-1:0]   SIDE_MAX    = SIZE_W'(MAX_SIDE);

    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_WEIGHT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLACE_TOP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLACE_LEFT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_COLS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_ROWS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERLAY_COLS = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERLAY_ROWS = 3'd6;

endpackage

`default_nettype wire

// ===== hw/rtl/clipped_alpha_blend_compositor_core.sv =====
// An accepted input transaction passes the stage-one register, then the output register.
// Throughput: one pixel per cycle when not stalled; position and blend/address stages are
// pipelined and the output register holds a result while the next pixel is accepted.
// Reset (synchronous, active low): registers return to their defaults and the row and
// column counters, the clipping flag and both stage valid bits clear.
// Uses cabc_pkg for register indexes, widths and size limits.
`default_nettype none

module clipped_alpha_blend_compositor_core
    import cabc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // src_red, src_green, src_blue, dst_red, dst_green, dst_blue
    input  wire logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // out_red, out_green, out_blue, canvas_address
    output logic [OUT_DATA_W-1:0]       o_m_axis_tdata,
    // write_enable
    output logic                        o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);

    logic [WEIGHT_W-1:0] r_blend_weight;
    logic [PLACE_W-1:0]  r_place_top;
    logic [PLACE_W-1:0]  r_place_left;
    logic [SIZE_W-1:0]   r_canvas_cols;
    logic [SIZE_W-1:0]   r_canvas_rows;
    logic [SIZE_W-1:0]   r_overlay_cols;
    logic [SIZE_W-1:0]   r_overlay_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight <= WEIGHT_FULL;
            r_place_top    <= '0;
            r_place_left   <= '0;
            r_canvas_cols  <= SIZE_W'(1);
            r_canvas_rows  <= SIZE_W'(1);
            r_overlay_cols <= SIZE_W'(1);
            r_overlay_rows <= SIZE_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BLEND_WEIGHT: r_blend_weight <= i_cfg_data[WEIGHT_W-1:0];
                CFG_PLACE_TOP:    r_place_top    <= i_cfg_data[PLACE_W-1:0];
                CFG_PLACE_LEFT:   r_place_left   <= i_cfg_data[PLACE_W-1:0];
                CFG_CANVAS_COLS:  r_canvas_cols  <= i_cfg_data[SIZE_W-1:0];
                CFG_CANVAS_ROWS:  r_canvas_rows  <= i_cfg_data[SIZE_W-1:0];
                CFG_OVERLAY_COLS: r_overlay_cols <= i_cfg_data[SIZE_W-1:0];
                CFG_OVERLAY_ROWS: r_overlay_rows <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [COUNT_W-1:0] r_row_count;
    logic [COUNT_W-1:0] r_col_count;
    logic               r_rows_exhausted;

    logic               r_s1_valid;
    logic [IN_DATA_W-1:0] r_s1_pixel;
    logic [SIZE_W-1:0]  r_s1_crow;
    logic [SIZE_W-1:0]  r_s1_ccol;
    logic               r_s1_we;
    logic               r_s1_last;

    logic               r_s2_valid;
    logic [OUT_DATA_W-1:0] r_s2_data;
    logic               r_s2_we;
    logic               r_s2_last;

    logic s2_load;
    logic s1_load;
    assign s2_load = !r_s2_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s2_load;
    assign s1_load = i_s_axis_tvalid && o_s_axis_tready;

    logic [SIZE_W-1:0] ocols;
    logic [SIZE_W-1:0] orows;
    logic [SIZE_W-1:0] crow;
    logic [SIZE_W-1:0] ccol;
    logic [SIZE_W-1:0] col_next;
    logic [SIZE_W-1:0] row_next;
    logic              exhausted_now;
    logic              we;
    logic              last_col;
    logic              last;

    always_comb begin
        if (r_overlay_cols == '0) begin
            ocols = SIZE_W'(1);
        end else if (r_overlay_cols > SIDE_MAX) begin
            ocols = SIDE_MAX;
        end else begin
            ocols = r_overlay_cols;
        end
        if (r_overlay_rows == '0) begin
            orows = SIZE_W'(1);
        end else if (r_overlay_rows > SIDE_MAX) begin
            orows = SIDE_MAX;
        end else begin
            orows = r_overlay_rows;
        end
        crow = {1'b0, r_place_top} + {1'b0, r_row_count};
        ccol = {1'b0, r_place_left} + {1'b0, r_col_count};
        col_next = {1'b0, r_col_count} + SIZE_W'(1);
        row_next = {1'b0, r_row_count} + SIZE_W'(1);
        exhausted_now = r_rows_exhausted || (crow >= r_canvas_rows);
        we = !exhausted_now && (ccol < r_canvas_cols);
        last_col = col_next >= ocols;
        last = last_col && (row_next >= orows);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count      <= '0;
            r_col_count      <= '0;
            r_rows_exhausted <= 1'b0;
            r_s1_valid       <= 1'b0;
        end else begin
            if (s1_load) begin
                if (last) begin
                    r_row_count      <= '0;
                    r_col_count      <= '0;
                    r_rows_exhausted <= 1'b0;
                end else if (last_col) begin
                    r_col_count      <= '0;
                    r_row_count      <= row_next[COUNT_W-1:0];
                    r_rows_exhausted <= exhausted_now;
                end else begin
                    r_col_count      <= col_next[COUNT_W-1:0];
                    r_rows_exhausted <= exhausted_now;
                end
            end
            if (o_s_axis_tready) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_pixel <= i_s_axis_tdata;
            r_s1_crow  <= crow;
            r_s1_ccol  <= ccol;
            r_s1_we    <= we;
            r_s1_last  <= last;
        end
    end

    logic [WEIGHT_W-1:0]     alpha;
    logic [WEIGHT_W-1:0]     alpha_inv;
    logic [CHAN_W-1:0]       mix_red;
    logic [CHAN_W-1:0]       mix_green;
    logic [CHAN_W-1:0]       mix_blue;
    logic [2*SIZE_W-1:0]     addr_full;
    logic [OUT_DATA_W-1:0]   s2_data;

    function automatic logic [CHAN_W-1:0] blend(
        input logic [CHAN_W-1:0]   dst,
        input logic [CHAN_W-1:0]   src,
        input logic [WEIGHT_W-1:0] a,
        input logic [WEIGHT_W-1:0] a_inv
    );
        logic [CHAN_W+WEIGHT_W-1:0] sum;
        sum = ({{WEIGHT_W{1'b0}}, dst} * {{CHAN_W{1'b0}}, a_inv})
            + ({{WEIGHT_W{1'b0}}, src} * {{CHAN_W{1'b0}}, a});
        return sum[2*CHAN_W-1:CHAN_W];
    endfunction

    always_comb begin
        alpha     = (r_blend_weight > WEIGHT_FULL) ? WEIGHT_FULL : r_blend_weight;
        alpha_inv = WEIGHT_FULL - alpha;
        mix_red   = blend(r_s1_pixel[31:24], r_s1_pixel[7:0], alpha, alpha_inv);
        mix_green = blend(r_s1_pixel[39:32], r_s1_pixel[15:8], alpha, alpha_inv);
        mix_blue  = blend(r_s1_pixel[47:40], r_s1_pixel[23:16], alpha, alpha_inv);
        addr_full = ({{SIZE_W{1'b0}}, r_s1_crow} * {{SIZE_W{1'b0}}, r_canvas_cols})
                  + {{SIZE_W{1'b0}}, r_s1_ccol};
        if (r_s1_we) begin
            s2_data = {addr_full[ADDR_W-1:0], mix_blue, mix_green, mix_red};
        end else begin
            s2_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            r_s2_data <= s2_data;
            r_s2_we   <= r_s1_we;
            r_s2_last <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_s2_valid;
    assign o_m_axis_tdata  = r_s2_data;
    assign o_m_axis_tuser  = r_s2_we;
    assign o_m_axis_tlast  = r_s2_last;

endmodule

`default_nettype wire
